// File: hdl/save_container_decoder_top_macros.svh
// assertion macros for the save container decoder
`ifndef SAVE_CONTAINER_DECODER_TOP_MACROS_SVH
`define SAVE_CONTAINER_DECODER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define SCD_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scd assertion failed");

// next-cycle implication, checked out of reset
`define SCD_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scd assertion failed");

`endif

// File: hdl/scd_pkg.sv
// shared types, constants and crc step for the save container decoder
`default_nettype none

package scd_pkg;

    localparam int unsigned CNT_W   = 34;
    localparam int unsigned HDR_LEN = 12;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [31:0] MAGIC_RST    = 32'h5A45_5441;
    localparam logic [63:0] KEY_LOW_RST  = 64'h7a65_7461_6c69_6b65;
    localparam logic [63:0] KEY_HIGH_RST = 64'h516f_5f4e_4f4f_4e21;
    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;

    localparam logic [1:0] REG_MAGIC     = 2'd0;
    localparam logic [1:0] REG_KEY_LOW   = 2'd1;
    localparam logic [1:0] REG_KEY_HIGH  = 2'd2;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_BAD_MAGIC = 3'd2,
        ST_BAD_LEN   = 3'd3,
        ST_BAD_CRC   = 3'd4
    } t_status;

    typedef struct packed {
        logic [31:0] magic;
        logic [63:0] key_low;
        logic [63:0] key_high;
    } t_cfg;

    // reflected crc-32 over one byte, bit loop unrolled
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: hdl/scd_apb_regs.sv
// apb configuration registers: magic word and keystream seeds
`default_nettype none

module scd_apb_regs
    import scd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    logic [31:0] r_magic;
    logic [63:0] r_key_low;
    logic [63:0] r_key_high;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic    <= MAGIC_RST;
            r_key_low  <= KEY_LOW_RST;
            r_key_high <= KEY_HIGH_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_MAGIC:    r_magic    <= pwdata[31:0];
                REG_KEY_LOW:  r_key_low  <= pwdata;
                REG_KEY_HIGH: r_key_high <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MAGIC:    prdata = {32'd0, r_magic};
            REG_KEY_LOW:  prdata = r_key_low;
            REG_KEY_HIGH: prdata = r_key_high;
            default:      prdata = 64'd0;
        endcase
    end

    assign o_cfg = '{magic: r_magic, key_low: r_key_low, key_high: r_key_high};

endmodule

`default_nettype wire

// File: hdl/save_container_decoder_top.sv
// save container decoder top: header parse, keystream xor, crc-32 check
// each accepted input beat is registered into the output register as its result beat
// throughput: one beat per cycle while not stalled; crc and keystream steps are combinational
// reset: synchronous active low, restores register defaults and seeds the first file
`default_nettype none
`include "save_container_decoder_top_macros.svh"

module save_container_decoder_top
    import scd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] file_byte
    input  wire logic        s_axis_tlast,   // last_byte
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [15:0] m_axis_tdata,   // [7:0] plain_byte, [10:8] status, [15:11] zero
    output logic             m_axis_tuser,   // plain_valid
    output logic             m_axis_tlast,   // done_res
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready
);

    t_cfg cfg;

    logic [CNT_W-1:0] r_byte_count, n_byte_count;
    logic [31:0]      r_hdr_magic, n_hdr_magic;
    logic [31:0]      r_hdr_len, n_hdr_len;
    logic [31:0]      r_hdr_crc, n_hdr_crc;
    logic [63:0]      r_key_a, n_key_a;
    logic [63:0]      r_key_b, n_key_b;
    logic [31:0]      r_crc, n_crc;

    logic             r_out_valid;
    logic [7:0]       r_out_plain, n_out_plain;
    logic             r_out_pvalid, n_out_pvalid;
    logic             r_out_done;
    t_status          r_out_status, n_out_status;

    logic             s_acc;
    logic [63:0]      key_x;
    logic [7:0]       key_byte;
    logic [CNT_W-1:0] len_total;

    scd_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    assign key_x    = r_key_a ^ r_key_b;
    assign key_byte = r_key_a[7:0] + r_key_b[7:0];

    always_comb begin
        n_hdr_magic  = r_hdr_magic;
        n_hdr_len    = r_hdr_len;
        n_hdr_crc    = r_hdr_crc;
        n_key_a      = r_key_a;
        n_key_b      = r_key_b;
        n_crc        = r_crc;
        n_out_plain  = 8'd0;
        n_out_pvalid = 1'b0;

        if (r_byte_count < CNT_W'(4)) begin
            n_hdr_magic = {r_hdr_magic[23:0], s_axis_tdata};
        end else if (r_byte_count < CNT_W'(8)) begin
            n_hdr_len = {r_hdr_len[23:0], s_axis_tdata};
        end else if (r_byte_count < CNT_W'(HDR_LEN)) begin
            n_hdr_crc = {r_hdr_crc[23:0], s_axis_tdata};
        end else begin
            n_out_plain  = s_axis_tdata ^ key_byte;
            n_out_pvalid = 1'b1;
            n_crc        = crc_byte(r_crc, n_out_plain);
            n_key_a      = {r_key_a[8:0], r_key_a[63:9]} ^ key_x ^ (key_x << 14);
            n_key_b      = {key_x[27:0], key_x[63:28]};
        end

        n_byte_count = (r_byte_count == CNT_MAX) ? r_byte_count : r_byte_count + 1'b1;
    end

    assign len_total = {2'd0, n_hdr_len} + CNT_W'(HDR_LEN);

    always_comb begin
        if (n_byte_count < CNT_W'(HDR_LEN)) begin
            n_out_status = ST_SHORT;
        end else if (n_hdr_magic != cfg.magic) begin
            n_out_status = ST_BAD_MAGIC;
        end else if (n_byte_count != len_total) begin
            n_out_status = ST_BAD_LEN;
        end else if (~n_crc != n_hdr_crc) begin
            n_out_status = ST_BAD_CRC;
        end else begin
            n_out_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_hdr_magic  <= '0;
            r_hdr_len    <= '0;
            r_hdr_crc    <= '0;
            r_key_a      <= KEY_LOW_RST;
            r_key_b      <= KEY_HIGH_RST;
            r_crc        <= CRC_INIT;
        end else if (s_acc) begin
            if (s_axis_tlast) begin
                r_byte_count <= '0;
                r_hdr_magic  <= '0;
                r_hdr_len    <= '0;
                r_hdr_crc    <= '0;
                r_key_a      <= cfg.key_low;
                r_key_b      <= cfg.key_high;
                r_crc        <= CRC_INIT;
            end else begin
                r_byte_count <= n_byte_count;
                r_hdr_magic  <= n_hdr_magic;
                r_hdr_len    <= n_hdr_len;
                r_hdr_crc    <= n_hdr_crc;
                r_key_a      <= n_key_a;
                r_key_b      <= n_key_b;
                r_crc        <= n_crc;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_out_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_out_plain  <= n_out_plain;
            r_out_pvalid <= n_out_pvalid;
            r_out_done   <= s_axis_tlast;
            r_out_status <= s_axis_tlast ? n_out_status : ST_OK;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_status, r_out_plain};
    assign m_axis_tuser  = r_out_pvalid;
    assign m_axis_tlast  = r_out_done;

    `SCD_ASSERT_NXT(a_reseed_clears_count, s_acc && s_axis_tlast, r_byte_count == '0)
    `SCD_ASSERT_NXT(a_count_monotonic, s_acc && !s_axis_tlast,
                    r_byte_count >= $past(r_byte_count))
    `SCD_ASSERT_IMP(a_status_only_on_done, m_axis_tvalid && !m_axis_tlast,
                    m_axis_tdata[10:8] == ST_OK)
    `SCD_ASSERT_IMP(a_plain_zero_in_header, m_axis_tvalid && !m_axis_tuser,
                    m_axis_tdata[7:0] == 8'd0)

endmodule

`default_nettype wire
